// ===== rtl/gsc_pkg.sv =====
// Shared types and constants of the gamepad stick conditioner.
package gsc_pkg;

    localparam int SQRT_STAGES = 17;
    localparam int DIV_STAGES  = 16;
    localparam int POW_STAGES  = 4;

    localparam logic [16:0] Q16_ONE       = 17'h10000;
    localparam logic [15:0] HALF_ROOT2    = 16'd23170;
    localparam logic [16:0] HALF_ROOT2_DV = 17'd23170;

    typedef enum logic [2:0] {
        REG_ENABLE        = 3'd0,
        REG_DEAD_ZONE     = 3'd1,
        REG_LOOK_EXPONENT = 3'd2,
        REG_SWAP_STICKS   = 3'd3,
        REG_INVERT_PITCH  = 3'd4,
        REG_YAW_GAIN      = 3'd5,
        REG_PITCH_GAIN    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic               vld;
        logic               en;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic [16:0]        mm;
        logic [16:0]        ml;
        logic               zm;
        logic               zl;
        logic               sm;
        logic               sl;
        logic signed [25:0] yaw;
        logic signed [25:0] pitch;
    } side_t;

endpackage

// ===== rtl/gsc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module gsc_sqrt (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic [33:0]   rad_i,
    input  gsc_pkg::side_t side_i,
    output logic [16:0]   root_o,
    output gsc_pkg::side_t side_o
);
    import gsc_pkg::*;

    logic [18:0] rem_reg  [SQRT_STAGES];
    logic [16:0] root_reg [SQRT_STAGES];
    logic [33:0] rad_reg  [SQRT_STAGES];
    side_t       side_reg [SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
        logic [18:0] rem_cur;
        logic [16:0] root_cur;
        logic [33:0] rad_cur;
        side_t       side_cur;
        logic [19:0] rem_sh;
        logic [19:0] trial;
        logic        take;

        if (i == 0) begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign rad_cur  = rad_i;
            assign side_cur = side_i;
        end else begin : g_next
            assign rem_cur  = rem_reg[i-1];
            assign root_cur = root_reg[i-1];
            assign rad_cur  = rad_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        assign rem_sh = {rem_cur[17:0], rad_cur[33:32]};
        assign trial  = {1'b0, root_cur, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[i].vld <= 1'b0;
            end else if (ce) begin
                side_reg[i] <= side_cur;
                rad_reg[i]  <= {rad_cur[31:0], 2'b00};
                root_reg[i] <= {root_cur[15:0], take};
                rem_reg[i]  <= take ? 19'(rem_sh - trial) : rem_sh[18:0];
            end
        end
    end

    assign root_o = root_reg[SQRT_STAGES-1];
    assign side_o = side_reg[SQRT_STAGES-1];

endmodule

// ===== rtl/gsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, 16-bit quotient.
module gsc_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic [31:0]   dividend_i,
    input  logic [16:0]   divisor_i,
    input  gsc_pkg::side_t side_i,
    output logic [15:0]   quot_o,
    output gsc_pkg::side_t side_o
);
    import gsc_pkg::*;

    logic [16:0] rem_reg [DIV_STAGES];
    logic [15:0] low_reg [DIV_STAGES];
    logic [15:0] quo_reg [DIV_STAGES];
    logic [16:0] dvs_reg [DIV_STAGES];
    side_t       side_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        logic [16:0] rem_cur;
        logic [15:0] low_cur;
        logic [15:0] quo_cur;
        logic [16:0] dvs_cur;
        side_t       side_cur;
        logic [17:0] t;
        logic        take;

        if (i == 0) begin : g_first
            assign rem_cur  = {1'b0, dividend_i[31:16]};
            assign low_cur  = dividend_i[15:0];
            assign quo_cur  = '0;
            assign dvs_cur  = divisor_i;
            assign side_cur = side_i;
        end else begin : g_next
            assign rem_cur  = rem_reg[i-1];
            assign low_cur  = low_reg[i-1];
            assign quo_cur  = quo_reg[i-1];
            assign dvs_cur  = dvs_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        assign t    = {rem_cur, low_cur[15]};
        assign take = (t >= {1'b0, dvs_cur});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[i].vld <= 1'b0;
            end else if (ce) begin
                side_reg[i] <= side_cur;
                dvs_reg[i]  <= dvs_cur;
                low_reg[i]  <= {low_cur[14:0], 1'b0};
                quo_reg[i]  <= {quo_cur[14:0], take};
                rem_reg[i]  <= take ? 17'(t - {1'b0, dvs_cur}) : t[16:0];
            end
        end
    end

    assign quot_o = quo_reg[DIV_STAGES-1];
    assign side_o = side_reg[DIV_STAGES-1];

endmodule

// ===== rtl/gamepad_stick_conditioner.sv =====
// Top level of the gamepad stick conditioner: registers, pipeline and result stage.
//
// One input beat carries one sample of both sticks; one output beat carries the
// strafe and forward moves and the yaw and pitch turns for that sample.
// Each stick passes through a circular deadzone with magnitude rescaling; the
// move stick is eased to full scale, the look magnitude is raised to a power.
// The pipeline takes one beat per cycle unless the receiver stalls it. Most of
// its depth comes from the 17-stage square root and the three 16-stage dividers
// that run one after another. Registers must be written over the APB port only
// while the pipeline is empty; the block itself does not enforce this.
// Reset clears all valid bits and loads the register defaults.
// When the receiver holds m_tready low with a beat waiting, the whole pipeline
// freezes and s_tready falls; nothing is lost or repeated.
module gamepad_stick_conditioner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_x, left_y, right_x, right_y
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // side_move, forward_move, yaw_turn, pitch_turn, two zero bits
    output logic [87:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gsc_pkg::*;

    logic        enable_reg;
    logic [15:0] dead_zone_reg;
    logic [2:0]  look_exponent_reg;
    logic        swap_sticks_reg;
    logic        invert_pitch_reg;
    logic [9:0]  yaw_gain_reg;
    logic [9:0]  pitch_gain_reg;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg        <= 1'b1;
            dead_zone_reg     <= 16'd11469;
            look_exponent_reg <= 3'd3;
            swap_sticks_reg   <= 1'b0;
            invert_pitch_reg  <= 1'b0;
            yaw_gain_reg      <= 10'd300;
            pitch_gain_reg    <= 10'd150;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_ENABLE:        enable_reg        <= pwdata[0];
                REG_DEAD_ZONE:     dead_zone_reg     <= pwdata[15:0];
                REG_LOOK_EXPONENT: look_exponent_reg <= pwdata[2:0];
                REG_SWAP_STICKS:   swap_sticks_reg   <= pwdata[0];
                REG_INVERT_PITCH:  invert_pitch_reg  <= pwdata[0];
                REG_YAW_GAIN:      yaw_gain_reg      <= pwdata[9:0];
                REG_PITCH_GAIN:    pitch_gain_reg    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ENABLE:        prdata = {31'd0, enable_reg};
            REG_DEAD_ZONE:     prdata = {16'd0, dead_zone_reg};
            REG_LOOK_EXPONENT: prdata = {29'd0, look_exponent_reg};
            REG_SWAP_STICKS:   prdata = {31'd0, swap_sticks_reg};
            REG_INVERT_PITCH:  prdata = {31'd0, invert_pitch_reg};
            REG_YAW_GAIN:      prdata = {22'd0, yaw_gain_reg};
            REG_PITCH_GAIN:    prdata = {22'd0, pitch_gain_reg};
            default:           prdata = '0;
        endcase
    end

    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // Input stage.
    side_t in_next;
    side_t in_reg;

    always_comb begin
        in_next     = '0;
        in_next.vld = s_tvalid;
        in_next.en  = enable_reg;
        if (swap_sticks_reg) begin
            in_next.mx = s_tdata[47:32];
            in_next.my = s_tdata[63:48];
            in_next.lx = s_tdata[15:0];
            in_next.ly = s_tdata[31:16];
        end else begin
            in_next.mx = s_tdata[15:0];
            in_next.my = s_tdata[31:16];
            in_next.lx = s_tdata[47:32];
            in_next.ly = s_tdata[63:48];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.vld <= 1'b0;
        end else if (ce) begin
            in_reg <= in_next;
        end
    end

    // Squared magnitudes.
    side_t       sq_reg;
    logic [33:0] radm_reg;
    logic [33:0] radl_reg;
    logic signed [31:0] mxx, myy, lxx, lyy;

    assign mxx = in_reg.mx * in_reg.mx;
    assign myy = in_reg.my * in_reg.my;
    assign lxx = in_reg.lx * in_reg.lx;
    assign lyy = in_reg.ly * in_reg.ly;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg.vld <= 1'b0;
        end else if (ce) begin
            sq_reg   <= in_reg;
            radm_reg <= {$unsigned(mxx) + $unsigned(myy), 2'b00};
            radl_reg <= {$unsigned(lxx) + $unsigned(lyy), 2'b00};
        end
    end

    logic [16:0] root_m, root_l;
    side_t       rt_side;

    gsc_sqrt u_sqrt_move (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .rad_i   (radm_reg),
        .side_i  (sq_reg),
        .root_o  (root_m),
        .side_o  (rt_side)
    );

    gsc_sqrt u_sqrt_look (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .rad_i   (radl_reg),
        .side_i  (sq_reg),
        .root_o  (root_l),
        .side_o  ()
    );

    // Deadzone test and rescale setup.
    side_t       dz_next;
    side_t       dz_reg;
    logic [31:0] dvdm_reg, dvdl_reg;
    logic [16:0] dvs_reg;

    always_comb begin
        dz_next    = rt_side;
        dz_next.mm = root_m;
        dz_next.ml = root_l;
        dz_next.zm = (root_m <= {1'b0, dead_zone_reg});
        dz_next.zl = (root_l <= {1'b0, dead_zone_reg});
        dz_next.sm = root_m[16];
        dz_next.sl = root_l[16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dz_reg.vld <= 1'b0;
        end else if (ce) begin
            dz_reg   <= dz_next;
            dvdm_reg <= {16'(root_m[15:0] - dead_zone_reg), 16'd0};
            dvdl_reg <= {16'(root_l[15:0] - dead_zone_reg), 16'd0};
            dvs_reg  <= 17'(Q16_ONE - {1'b0, dead_zone_reg});
        end
    end

    logic [15:0] qn_m, qn_l;
    side_t       rs_side;

    gsc_div u_div_rescale_m (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .dividend_i (dvdm_reg),
        .divisor_i  (dvs_reg),
        .side_i     (dz_reg),
        .quot_o     (qn_m),
        .side_o     (rs_side)
    );

    gsc_div u_div_rescale_l (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .dividend_i (dvdl_reg),
        .divisor_i  (dvs_reg),
        .side_i     (dz_reg),
        .quot_o     (qn_l),
        .side_o     ()
    );

    // Rescaled magnitudes.
    side_t       n_reg;
    logic [16:0] nm_reg, nl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg.vld <= 1'b0;
        end else if (ce) begin
            n_reg  <= rs_side;
            nm_reg <= rs_side.zm ? 17'd0 : (rs_side.sm ? Q16_ONE : {1'b0, qn_m});
            nl_reg <= rs_side.zl ? 17'd0 : (rs_side.sl ? Q16_ONE : {1'b0, qn_l});
        end
    end

    // Look magnitude power, one multiply per stage.
    logic [2:0] exp_eff;
    assign exp_eff = (look_exponent_reg == 3'd0) ? 3'd1 :
                     (look_exponent_reg > 3'd4)  ? 3'd4 : look_exponent_reg;

    side_t       pw_side [POW_STAGES];
    logic [16:0] pw_p    [POW_STAGES];
    logic [16:0] pw_n    [POW_STAGES];
    logic [16:0] pw_m    [POW_STAGES];

    for (genvar k = 0; k < POW_STAGES; k++) begin : g_pow
        side_t       s_cur;
        logic [16:0] p_cur, n_cur, m_cur;
        logic [33:0] prod;

        if (k == 0) begin : g_first
            assign s_cur = n_reg;
            assign p_cur = Q16_ONE;
            assign n_cur = nl_reg;
            assign m_cur = nm_reg;
        end else begin : g_next
            assign s_cur = pw_side[k-1];
            assign p_cur = pw_p[k-1];
            assign n_cur = pw_n[k-1];
            assign m_cur = pw_m[k-1];
        end

        assign prod = p_cur * n_cur;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pw_side[k].vld <= 1'b0;
            end else if (ce) begin
                pw_side[k] <= s_cur;
                pw_n[k]    <= n_cur;
                pw_m[k]    <= m_cur;
                pw_p[k]    <= (3'(k) < exp_eff) ? prod[32:16] : p_cur;
            end
        end
    end

    // Axis magnitude times scale.
    side_t       ax_reg;
    logic [31:0] axm_reg, aym_reg, axl_reg, ayl_reg;
    logic [15:0] abs_mx, abs_my, abs_lx, abs_ly;
    side_t       pw_last;
    logic [16:0] pm_last, pl_last;

    assign pw_last = pw_side[POW_STAGES-1];
    assign pm_last = pw_m[POW_STAGES-1];
    assign pl_last = pw_p[POW_STAGES-1];
    assign abs_mx  = pw_last.mx[15] ? 16'(-pw_last.mx) : pw_last.mx;
    assign abs_my  = pw_last.my[15] ? 16'(-pw_last.my) : pw_last.my;
    assign abs_lx  = pw_last.lx[15] ? 16'(-pw_last.lx) : pw_last.lx;
    assign abs_ly  = pw_last.ly[15] ? 16'(-pw_last.ly) : pw_last.ly;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg.vld <= 1'b0;
        end else if (ce) begin
            ax_reg  <= pw_last;
            axm_reg <= 32'(abs_mx * pm_last);
            aym_reg <= 32'(abs_my * pm_last);
            axl_reg <= 32'(abs_lx * pl_last);
            ayl_reg <= 32'(abs_ly * pl_last);
        end
    end

    logic [15:0] q_mx, q_my, q_lx, q_ly;
    side_t       ax_side;

    gsc_div u_div_mx (
        .aclk (aclk), .aresetn (aresetn), .ce (ce),
        .dividend_i (axm_reg), .divisor_i (ax_reg.mm), .side_i (ax_reg),
        .quot_o (q_mx), .side_o (ax_side)
    );

    gsc_div u_div_my (
        .aclk (aclk), .aresetn (aresetn), .ce (ce),
        .dividend_i (aym_reg), .divisor_i (ax_reg.mm), .side_i (ax_reg),
        .quot_o (q_my), .side_o ()
    );

    gsc_div u_div_lx (
        .aclk (aclk), .aresetn (aresetn), .ce (ce),
        .dividend_i (axl_reg), .divisor_i (ax_reg.ml), .side_i (ax_reg),
        .quot_o (q_lx), .side_o ()
    );

    gsc_div u_div_ly (
        .aclk (aclk), .aresetn (aresetn), .ce (ce),
        .dividend_i (ayl_reg), .divisor_i (ax_reg.ml), .side_i (ax_reg),
        .quot_o (q_ly), .side_o ()
    );

    // Move clamp and look gains.
    side_t       ez_next;
    side_t       ez_reg;
    logic [31:0] em_x_reg, em_y_reg;
    logic [15:0] mv_x, mv_y, lk_x, lk_y, cl_x, cl_y;
    logic [25:0] yaw_mag, pitch_mag;

    always_comb begin
        mv_x      = ax_side.zm ? 16'd0 : q_mx;
        mv_y      = ax_side.zm ? 16'd0 : q_my;
        lk_x      = ax_side.zl ? 16'd0 : q_lx;
        lk_y      = ax_side.zl ? 16'd0 : q_ly;
        cl_x      = (mv_x > HALF_ROOT2) ? HALF_ROOT2 : mv_x;
        cl_y      = (mv_y > HALF_ROOT2) ? HALF_ROOT2 : mv_y;
        yaw_mag   = lk_x * yaw_gain_reg;
        pitch_mag = lk_y * pitch_gain_reg;
        ez_next   = ax_side;
        ez_next.yaw   = ax_side.lx[15] ? $signed(yaw_mag) : -$signed(yaw_mag);
        ez_next.pitch = (ax_side.ly[15] ^ invert_pitch_reg) ? -$signed(pitch_mag)
                                                            : $signed(pitch_mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ez_reg.vld <= 1'b0;
        end else if (ce) begin
            ez_reg   <= ez_next;
            em_x_reg <= {1'b0, cl_x, 15'd0};
            em_y_reg <= {1'b0, cl_y, 15'd0};
        end
    end

    logic [15:0] ex_q, ey_q;
    side_t       fin_side;

    gsc_div u_div_ease_x (
        .aclk (aclk), .aresetn (aresetn), .ce (ce),
        .dividend_i (em_x_reg), .divisor_i (HALF_ROOT2_DV), .side_i (ez_reg),
        .quot_o (ex_q), .side_o (fin_side)
    );

    gsc_div u_div_ease_y (
        .aclk (aclk), .aresetn (aresetn), .ce (ce),
        .dividend_i (em_y_reg), .divisor_i (HALF_ROOT2_DV), .side_i (ez_reg),
        .quot_o (ey_q), .side_o ()
    );

    // Result register.
    logic               out_vld_reg;
    logic signed [16:0] side_move_reg, forward_move_reg;
    logic signed [25:0] yaw_turn_reg, pitch_turn_reg;
    logic signed [16:0] ex_s, ey_s;

    assign ex_s = $signed({1'b0, ex_q});
    assign ey_s = $signed({1'b0, ey_q});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            out_vld_reg <= fin_side.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (fin_side.en) begin
                side_move_reg    <= fin_side.mx[15] ? -ex_s : ex_s;
                forward_move_reg <= fin_side.my[15] ? ey_s : -ey_s;
                yaw_turn_reg     <= fin_side.yaw;
                pitch_turn_reg   <= fin_side.pitch;
            end else begin
                side_move_reg    <= '0;
                forward_move_reg <= '0;
                yaw_turn_reg     <= '0;
                pitch_turn_reg   <= '0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, pitch_turn_reg, yaw_turn_reg, forward_move_reg, side_move_reg};

endmodule
